[hdl/palette_text_parse_and_swap_macros.svh]
// Assertion macros shared by the palette parser and swapper checker.
`ifndef PALETTE_TEXT_PARSE_AND_SWAP_MACROS_SVH
`define PALETTE_TEXT_PARSE_AND_SWAP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PTS_ASSERT_NOW(lbl, clk_sig, rst_sig, ante, cons) \
	lbl: assert property (@(posedge clk_sig) disable iff (!(rst_sig)) (ante) |-> (cons)) \
		else $error("pts check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PTS_ASSERT_NEXT(lbl, clk_sig, rst_sig, ante, cons) \
	lbl: assert property (@(posedge clk_sig) disable iff (!(rst_sig)) (ante) |=> (cons)) \
		else $error("pts check failed");

`endif

[hdl/pts_pkg.sv]
// Package: types, constants and character helpers for the palette parser and swapper.
`default_nettype none

package pts_pkg;

	// Table size and derived widths
	localparam int MAX_ENTRIES = 16;
	localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int CNT_OUT_W   = 5;

	// Action codes
	localparam logic [1:0] ACT_BEGIN = 2'd0;
	localparam logic [1:0] ACT_CHAR  = 2'd1;
	localparam logic [1:0] ACT_END   = 2'd2;
	localparam logic [1:0] ACT_PIXEL = 2'd3;

	// Error codes
	localparam logic [3:0] ERR_NONE      = 4'd0;
	localparam logic [3:0] ERR_SRC_START = 4'd1;
	localparam logic [3:0] ERR_SRC_CHAR  = 4'd2;
	localparam logic [3:0] ERR_NEED_EQ   = 4'd3;
	localparam logic [3:0] ERR_DST_START = 4'd4;
	localparam logic [3:0] ERR_DST_CHAR  = 4'd5;
	localparam logic [3:0] ERR_NEED_SPLT = 4'd6;
	localparam logic [3:0] ERR_EARLY_END = 4'd7;
	localparam logic [3:0] ERR_NO_ENTRY  = 4'd8;
	localparam logic [3:0] ERR_FULL      = 4'd9;
	localparam logic [3:0] ERR_MAX       = ERR_FULL;

	// Pixel masks
	localparam logic [31:0] COLOR_MASK = 32'h00FF_FFFF;
	localparam logic [31:0] ALPHA_MASK = 32'hFF00_0000;

	// One transaction as it moves down the cell row
	typedef struct packed {
		logic [31:0]      pixel;
		logic             matched;
		logic             swap;
		logic [3:0]       err;
		logic [CNT_W-1:0] cnt;
		logic             ready;
		logic             wr;
		logic [IDX_W-1:0] widx;
		logic [31:0]      wsrc;
		logic [31:0]      wdst;
	} pts_item_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return ((c >= "0") && (c <= "9")) || ((c >= "A") && (c <= "F")) ||
			((c >= "a") && (c <= "f"));
	endfunction

	function automatic logic is_assign(input logic [7:0] c);
		return (c == "=") || (c == ">");
	endfunction

	function automatic logic is_split(input logic [7:0] c);
		return (c == ";") || (c == ",");
	endfunction

	// Letters have bit 6 set and low nibble 1..6
	function automatic logic [3:0] hex_value(input logic [7:0] c);
		return c[6] ? (c[3:0] + 4'd9) : c[3:0];
	endfunction

endpackage

`default_nettype wire

[hdl/pts_parser.sv]
// Text parser: phase, accumulators, count, sticky error and the head register of the row.
`default_nettype none

module pts_parser (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic              adv,
	input  wire logic [1:0]        action,
	input  wire logic [7:0]        text_char,
	input  wire logic [31:0]       pixel_in,
	output logic                   head_vld,
	output pts_pkg::pts_item_t     head_item
);
	import pts_pkg::*;

	typedef enum logic [2:0] {
		PH_BEFORE,
		PH_SRC,
		PH_SRC_WS,
		PH_EQ,
		PH_DST,
		PH_DST_WS
	} phase_t;

	phase_t           phase_q, phase_d;
	logic [31:0]      src_q, src_d;
	logic [31:0]      dst_q, dst_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [3:0]       err_q, err_d;
	logic             ready_q, ready_d;
	logic             vld_q;
	pts_item_t        item_q;
	pts_item_t        item_d;
	logic             busy;
	logic             store;
	logic [3:0]       hv;

	assign busy = (err_q == ERR_NONE) && !ready_q;
	assign hv   = hex_value(text_char);

	// Next parser state and the transaction built from it
	always_comb begin
		phase_d = phase_q;
		src_d   = src_q;
		dst_d   = dst_q;
		cnt_d   = cnt_q;
		err_d   = err_q;
		ready_d = ready_q;
		store   = 1'b0;
		item_d  = '0;
		item_d.pixel = pixel_in;

		case (action)
			ACT_BEGIN: begin
				phase_d = PH_BEFORE;
				src_d   = '0;
				dst_d   = '0;
				cnt_d   = '0;
				err_d   = ERR_NONE;
				ready_d = 1'b0;
			end
			ACT_CHAR: begin
				if (busy) begin
					case (phase_q)
						PH_BEFORE: begin
							if (is_hex(text_char)) begin
								src_d   = {28'd0, hv};
								phase_d = PH_SRC;
							end else if (!is_space(text_char)) begin
								err_d = ERR_SRC_START;
							end
						end
						PH_SRC: begin
							if (is_hex(text_char))
								src_d = {src_q[27:0], hv};
							else if (is_space(text_char))
								phase_d = PH_SRC_WS;
							else if (is_assign(text_char))
								phase_d = PH_EQ;
							else
								err_d = ERR_SRC_CHAR;
						end
						PH_SRC_WS: begin
							if (is_assign(text_char))
								phase_d = PH_EQ;
							else if (!is_space(text_char))
								err_d = ERR_NEED_EQ;
						end
						PH_EQ: begin
							if (is_hex(text_char)) begin
								dst_d   = {28'd0, hv};
								phase_d = PH_DST;
							end else if (!is_space(text_char)) begin
								err_d = ERR_DST_START;
							end
						end
						PH_DST: begin
							if (is_hex(text_char)) begin
								dst_d = {dst_q[27:0], hv};
							end else if (is_space(text_char) || is_split(text_char)) begin
								store   = 1'b1;
								phase_d = is_split(text_char) ? PH_BEFORE : PH_DST_WS;
							end else begin
								err_d = ERR_DST_CHAR;
							end
						end
						default: begin
							if (is_split(text_char))
								phase_d = PH_BEFORE;
							else if (!is_space(text_char))
								err_d = ERR_NEED_SPLT;
						end
					endcase
				end
			end
			ACT_END: begin
				if (busy) begin
					if (phase_q == PH_DST) begin
						store   = 1'b1;
						phase_d = PH_DST_WS;
					end
					if ((phase_q != PH_BEFORE) && (phase_q != PH_DST) &&
						(phase_q != PH_DST_WS)) begin
						err_d = ERR_EARLY_END;
					end else if (store && (cnt_q >= CNT_W'(MAX_ENTRIES))) begin
						err_d = ERR_FULL;
					end else if (!store && (cnt_q == '0)) begin
						err_d = ERR_NO_ENTRY;
					end else begin
						ready_d = 1'b1;
					end
				end
			end
			default: begin
				item_d.swap = ready_q && (err_q == ERR_NONE);
			end
		endcase

		// Pair store into the row, or table full
		if (store) begin
			if (cnt_q >= CNT_W'(MAX_ENTRIES)) begin
				err_d = ERR_FULL;
			end else begin
				item_d.wr   = 1'b1;
				item_d.widx = cnt_q[IDX_W-1:0];
				item_d.wsrc = src_d;
				item_d.wdst = dst_d;
				cnt_d       = cnt_q + CNT_W'(1);
			end
		end

		item_d.err   = err_d;
		item_d.cnt   = cnt_d;
		item_d.ready = ready_d;
	end

	// Parser state and head register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_BEFORE;
			src_q   <= '0;
			dst_q   <= '0;
			cnt_q   <= '0;
			err_q   <= ERR_NONE;
			ready_q <= 1'b0;
			vld_q   <= 1'b0;
		end else begin
			if (accept) begin
				phase_q <= phase_d;
				src_q   <= src_d;
				dst_q   <= dst_d;
				cnt_q   <= cnt_d;
				err_q   <= err_d;
				ready_q <= ready_d;
			end
			if (adv)
				vld_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			item_q <= item_d;
	end

	assign head_vld  = vld_q;
	assign head_item = item_q;

endmodule

`default_nettype wire

[hdl/pts_cell.sv]
// One table cell: holds an entry pair, takes its write, and matches passing pixels.
`default_nettype none

module pts_cell (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      adv,
	input  wire logic [pts_pkg::IDX_W-1:0] idx,
	input  wire logic                      in_vld,
	input  wire pts_pkg::pts_item_t        in_item,
	output logic                           out_vld,
	output pts_pkg::pts_item_t             out_item
);
	import pts_pkg::*;

	logic [31:0] src_q;
	logic [31:0] dst_q;
	logic        vld_q;
	pts_item_t   item_q;
	pts_item_t   item_d;
	logic        hit;

	// First match wins: only a transaction not yet matched looks here
	assign hit = in_item.swap && !in_item.matched && (CNT_W'(idx) < in_item.cnt) &&
		(src_q == (in_item.pixel & COLOR_MASK));

	always_comb begin
		item_d = in_item;
		if (hit) begin
			item_d.pixel   = dst_q | (in_item.pixel & ALPHA_MASK);
			item_d.matched = 1'b1;
		end
	end

	// Entry write from a passing store
	always_ff @(posedge clk) begin
		if (adv && in_vld && in_item.wr && (in_item.widx == idx)) begin
			src_q <= in_item.wsrc;
			dst_q <= in_item.wdst;
		end
		if (adv)
			item_q <= item_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= 1'b0;
		else if (adv)
			vld_q <= in_vld;
	end

	assign out_vld  = vld_q;
	assign out_item = item_q;

endmodule

`default_nettype wire

[hdl/palette_text_parse_and_swap.sv]
// Top level: palette text parser feeding a row of table cells that swap pixel colors.
//
//   channel | direction | handshake           | payload
//   input   | in        | in_valid / in_stall | action, text_char, pixel_in
//   output  | out       | out_valid/out_stall | pixel_out, matched, error_code,
//           |           |                     | entry_count, ready_res
//
// One transaction per clock while the output is not stalled; each one passes through
// the parser head register and then one register per table cell.
// The whole row advances together whenever its last register is empty or being taken;
// an output stall while a result waits in the last register holds every stage and raises in_stall.
// Reset clears the parser state and all valid bits; table entries are undefined until
// written and are never read beyond the stored count.
`default_nettype none

module palette_text_parse_and_swap (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  action,
	input  wire logic [7:0]  text_char,
	input  wire logic [31:0] pixel_in,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      pixel_out,
	output logic             matched,
	output logic [3:0]       error_code,
	output logic [4:0]       entry_count,
	output logic             ready_res
);
	import pts_pkg::*;

	logic                 adv;
	logic                 accept;
	logic [MAX_ENTRIES:0] vld;
	pts_item_t            itm [MAX_ENTRIES+1];

	// Row moves when the last stage is free or drained
	assign adv      = !vld[MAX_ENTRIES] || !out_stall;
	assign in_stall = !adv;
	assign accept   = in_valid && adv;

	pts_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.adv       (adv),
		.action    (action),
		.text_char (text_char),
		.pixel_in  (pixel_in),
		.head_vld  (vld[0]),
		.head_item (itm[0])
	);

	// Cell row, one entry per cell
	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		pts_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.idx      (IDX_W'(i)),
			.in_vld   (vld[i]),
			.in_item  (itm[i]),
			.out_vld  (vld[i+1]),
			.out_item (itm[i+1])
		);
	end

	assign out_valid   = vld[MAX_ENTRIES];
	assign pixel_out   = itm[MAX_ENTRIES].pixel;
	assign matched     = itm[MAX_ENTRIES].matched;
	assign error_code  = itm[MAX_ENTRIES].err;
	assign entry_count = CNT_OUT_W'(itm[MAX_ENTRIES].cnt);
	assign ready_res   = itm[MAX_ENTRIES].ready;

endmodule

`default_nettype wire

[hdl/pts_checker.sv]
// Port checker for the palette parser and swapper, bound to the top level.
`default_nettype none

`include "palette_text_parse_and_swap_macros.svh"

module pts_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [31:0] pixel_out,
	input wire logic        matched,
	input wire logic [3:0]  error_code,
	input wire logic [4:0]  entry_count,
	input wire logic        ready_res
);
	import pts_pkg::*;

	// A stalled result holds
	`PTS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable({pixel_out, entry_count}))

	// Input is held off only while a result waits on a stalled output
	`PTS_ASSERT_NOW(a_stall_full, clk, arst_n, in_stall, out_valid && out_stall)

	// Swap only happens on an accepted, error-free palette
	`PTS_ASSERT_NOW(a_match_ready, clk, arst_n, out_valid && matched, ready_res && (error_code == ERR_NONE))

	// A sticky error and an accepted palette exclude each other
	`PTS_ASSERT_NOW(a_err_not_ready, clk, arst_n, out_valid && (error_code != ERR_NONE), !ready_res)

	// Only defined error codes appear
	`PTS_ASSERT_NOW(a_err_range, clk, arst_n, out_valid, error_code <= ERR_MAX)

endmodule

bind palette_text_parse_and_swap pts_checker u_pts_checker (.*);

`default_nettype wire
